### rtl/priority_message_queue_with_caps_unit_defines.svh
// ----------------------------------------------------------------------------
// priority message queue assertion macros
// Shared concurrent assertion forms, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_MESSAGE_QUEUE_WITH_CAPS_UNIT_DEFINES_SVH
`define PRIORITY_MESSAGE_QUEUE_WITH_CAPS_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmq assertion failed");
`define PMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmq assertion failed");
`else
`define PMQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg
// Types, codes and sizes shared by the priority message queue modules.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int PRIORITY_LEVELS = 4;
    localparam int LEVEL_DEPTH     = 64;

    localparam int ACT_W   = 2;
    localparam int PRI_W   = 2;
    localparam int TAG_W   = 16;
    localparam int SIZE_W  = 24;
    localparam int STAT_W  = 2;
    localparam int TOTC_W  = 16;
    localparam int BYTES_W = 32;
    localparam int LCAP_W  = 16;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 1;
    localparam int REJ_W   = 16;

    localparam int LEVEL_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int LCNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int ENTRIES = PRIORITY_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_ENQ    = 2'd0,
        ACT_DEQ_HI = 2'd1,
        ACT_DEQ_LV = 2'd2,
        ACT_PEEK   = 2'd3
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 2'd0,
        ST_BACKPRESSURE = 2'd1,
        ST_EMPTY        = 2'd2,
        ST_OVERFLOW     = 2'd3
    } stat_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_LENGTH_CAP = 1'd0,
        CFG_BYTES_CAP  = 1'd1
    } cfg_idx_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } pmq_cmd_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
    } pmq_entry_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(LEVEL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

### rtl/pmq_ctrl.sv
// ----------------------------------------------------------------------------
// pmq_ctrl
// Sequencer: takes a request, runs the execute state, then strobes the result.
// ----------------------------------------------------------------------------
module pmq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output pmq_pkg::pmq_cmd_t cmd
);
    import pmq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;
    logic        done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            CTRL_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = CTRL_EXEC;
                end
            end
            CTRL_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = CTRL_IDLE;
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != CTRL_IDLE);
    assign done = done_reg;

endmodule

### rtl/pmq_dpath.sv
// ----------------------------------------------------------------------------
// pmq_dpath
// Per-level FIFO pointers, entry memory, totals, caps and result registers.
// ----------------------------------------------------------------------------
module pmq_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pmq_pkg::pmq_cmd_t                   cmd,
    input  logic [pmq_pkg::ACT_W-1:0]           action,
    input  logic [pmq_pkg::PRI_W-1:0]           priority_req,
    input  logic                                is_request,
    input  logic [pmq_pkg::TAG_W-1:0]           message_tag,
    input  logic [pmq_pkg::SIZE_W-1:0]          payload_size,
    input  logic                                cfg_we,
    input  logic [pmq_pkg::CIDX_W-1:0]          cfg_index,
    input  logic [pmq_pkg::CFG_W-1:0]           cfg_data,
    output logic [pmq_pkg::STAT_W-1:0]          status,
    output logic [pmq_pkg::TAG_W-1:0]           out_tag,
    output logic [pmq_pkg::PRI_W-1:0]           out_priority,
    output logic [pmq_pkg::SIZE_W-1:0]          out_size,
    output logic                                feed_event,
    output logic [pmq_pkg::TOTC_W-1:0]          total_count,
    output logic [pmq_pkg::BYTES_W-1:0]         total_bytes
);
    import pmq_pkg::*;

    // latched request
    act_t              act_reg;
    logic [PRI_W-1:0]  lv_reg;
    logic              isreq_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SIZE_W-1:0] psz_reg;

    // queue state
    logic [PTR_W-1:0]   head_reg [PRIORITY_LEVELS];
    logic [PTR_W-1:0]   head_next [PRIORITY_LEVELS];
    logic [PTR_W-1:0]   tail_reg [PRIORITY_LEVELS];
    logic [PTR_W-1:0]   tail_next [PRIORITY_LEVELS];
    logic [LCNT_W-1:0]  lcnt_reg [PRIORITY_LEVELS];
    logic [LCNT_W-1:0]  lcnt_next [PRIORITY_LEVELS];
    logic [COUNT_W-1:0] qcount_reg;
    logic [COUNT_W-1:0] qcount_next;
    logic [BYTES_W-1:0] qbytes_reg;
    logic [BYTES_W-1:0] qbytes_next;
    logic [REJ_W-1:0]   rej_reg;
    logic [REJ_W-1:0]   rej_next;
    logic               pop_pend_reg;
    logic               pop_pend_next;
    logic [LCAP_W-1:0]  length_cap_reg;
    logic [BYTES_W-1:0] bytes_cap_reg;

    // entry memory
    pmq_entry_t mem [ENTRIES];
    pmq_entry_t rdata_reg;
    logic       mem_we;
    logic       mem_re;
    logic [ADDR_W-1:0] mem_addr;

    // result
    stat_t            status_reg;
    stat_t            status_next;
    logic             hit_reg;
    logic             hit_next;
    logic [PRI_W-1:0] opri_reg;
    logic [PRI_W-1:0] opri_next;
    logic             feed_reg;
    logic             feed_next;

    // decode
    logic               lv_ok;
    logic [LEVEL_W-1:0] lvi;
    logic               hi_found;
    logic [LEVEL_W-1:0] hi_lv;
    logic               cap_hit;
    logic               pop;
    logic [LEVEL_W-1:0] pop_lv;

    always_comb
    begin
        lv_ok   = (int'(lv_reg) < PRIORITY_LEVELS);
        lvi     = LEVEL_W'(lv_reg);
        hi_found = 1'b0;
        hi_lv    = '0;
        for (int k = 0; k < PRIORITY_LEVELS; k++)
        begin
            if (lcnt_reg[k] != '0)
            begin
                hi_found = 1'b1;
                hi_lv    = LEVEL_W'(k);
            end
        end
        cap_hit = isreq_reg &&
                  (((bytes_cap_reg != '0) && (qbytes_reg >= bytes_cap_reg)) ||
                   ((length_cap_reg != '0) && (LCAP_W'(qcount_reg) >= length_cap_reg)));

        head_next     = head_reg;
        tail_next     = tail_reg;
        lcnt_next     = lcnt_reg;
        qcount_next   = qcount_reg;
        qbytes_next   = qbytes_reg;
        rej_next      = rej_reg;
        pop_pend_next = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = '0;
        status_next   = status_reg;
        hit_next      = hit_reg;
        opri_next     = opri_reg;
        feed_next     = feed_reg;
        pop           = 1'b0;
        pop_lv        = lvi;

        // size of a popped entry comes back from memory registered, in the cycle after the pop
        if (pop_pend_reg)
        begin
            qbytes_next = qbytes_reg - BYTES_W'(rdata_reg.size);
        end

        if (cmd.exec)
        begin
            status_next = ST_EMPTY;
            hit_next    = 1'b0;
            opri_next   = '0;
            feed_next   = 1'b0;
            unique case (act_reg)
                ACT_ENQ:
                begin
                    priority if (cap_hit)
                    begin
                        status_next = ST_BACKPRESSURE;
                        if (rej_reg != {REJ_W{1'b1}})
                        begin
                            rej_next = rej_reg + REJ_W'(1);
                        end
                    end
                    else if (!lv_ok || (lcnt_reg[lvi] == LCNT_W'(LEVEL_DEPTH)))
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        status_next    = ST_OK;
                        mem_we         = 1'b1;
                        mem_addr       = ADDR_W'(int'(lvi) * LEVEL_DEPTH
                                                 + int'(tail_reg[lvi]));
                        tail_next[lvi] = ptr_inc(tail_reg[lvi]);
                        lcnt_next[lvi] = lcnt_reg[lvi] + LCNT_W'(1);
                        qcount_next    = qcount_reg + COUNT_W'(1);
                        qbytes_next    = qbytes_reg + BYTES_W'(psz_reg);
                    end
                end
                ACT_DEQ_HI:
                begin
                    if (hi_found)
                    begin
                        pop    = 1'b1;
                        pop_lv = hi_lv;
                    end
                end
                ACT_DEQ_LV:
                begin
                    if (lv_ok && (lcnt_reg[lvi] != '0))
                    begin
                        pop = 1'b1;
                    end
                end
                ACT_PEEK:
                begin
                    if (lv_ok && (lcnt_reg[lvi] != '0))
                    begin
                        mem_re      = 1'b1;
                        mem_addr    = ADDR_W'(int'(lvi) * LEVEL_DEPTH
                                              + int'(head_reg[lvi]));
                        status_next = ST_OK;
                        hit_next    = 1'b1;
                        opri_next   = PRI_W'(lvi);
                    end
                end
                default:
                begin
                    status_next = ST_EMPTY;
                end
            endcase

            if (pop)
            begin
                mem_re            = 1'b1;
                mem_addr          = ADDR_W'(int'(pop_lv) * LEVEL_DEPTH
                                            + int'(head_reg[pop_lv]));
                head_next[pop_lv] = ptr_inc(head_reg[pop_lv]);
                lcnt_next[pop_lv] = lcnt_reg[pop_lv] - LCNT_W'(1);
                qcount_next       = qcount_reg - COUNT_W'(1);
                pop_pend_next     = 1'b1;
                status_next       = ST_OK;
                hit_next          = 1'b1;
                opri_next         = PRI_W'(pop_lv);
                if (rej_reg != '0)
                begin
                    rej_next  = rej_reg - REJ_W'(1);
                    feed_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PRIORITY_LEVELS; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
                lcnt_reg[k] <= '0;
            end
            qcount_reg     <= '0;
            qbytes_reg     <= '0;
            rej_reg        <= '0;
            pop_pend_reg   <= 1'b0;
            length_cap_reg <= '0;
            bytes_cap_reg  <= '0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            lcnt_reg     <= lcnt_next;
            qcount_reg   <= qcount_next;
            qbytes_reg   <= qbytes_next;
            rej_reg      <= rej_next;
            pop_pend_reg <= pop_pend_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_LENGTH_CAP)
                begin
                    length_cap_reg <= cfg_data[LCAP_W-1:0];
                end
                if (cfg_index == CFG_BYTES_CAP)
                begin
                    bytes_cap_reg <= cfg_data[BYTES_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= act_t'(action);
            lv_reg    <= priority_req;
            isreq_reg <= is_request;
            tag_reg   <= message_tag;
            psz_reg   <= payload_size;
        end
        status_reg <= status_next;
        hit_reg    <= hit_next;
        opri_reg   <= opri_next;
        feed_reg   <= feed_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= '{tag: tag_reg, size: psz_reg};
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign status       = status_reg;
    assign out_tag      = hit_reg ? rdata_reg.tag : '0;
    assign out_size     = hit_reg ? rdata_reg.size : '0;
    assign out_priority = opri_reg;
    assign feed_event   = feed_reg;
    assign total_count  = TOTC_W'(qcount_reg);
    assign total_bytes  = pop_pend_reg ? (qbytes_reg - BYTES_W'(rdata_reg.size))
                                       : qbytes_reg;

endmodule

### rtl/priority_message_queue_with_caps_unit.sv
// ----------------------------------------------------------------------------
// priority_message_queue_with_caps_unit
// Strict priority message queue, one FIFO per level, with length and byte
// caps on requests.
//
//   channel   | handshake         | fields
//   ----------+-------------------+---------------------------------------------
//   request   | start, busy       | action, priority_req, is_request,
//             |                   | message_tag, payload_size
//   result    | done (strobe)     | status, out_tag, out_priority, out_size,
//             |                   | feed_event, total_count, total_bytes
//   config    | cfg_we            | cfg_index, cfg_data
//
// a request runs the execute state on the single port of the entry memory,
// then the result strobe, during which busy is low and the next request is
// taken
// done is high for one cycle; the receiver cannot stall it
// reset clears all level pointers, counts, totals and caps; no clearing pass
// ----------------------------------------------------------------------------
`include "priority_message_queue_with_caps_unit_defines.svh"

module priority_message_queue_with_caps_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pmq_pkg::ACT_W-1:0]      action,
    input  logic [pmq_pkg::PRI_W-1:0]      priority_req,
    input  logic                           is_request,
    input  logic [pmq_pkg::TAG_W-1:0]      message_tag,
    input  logic [pmq_pkg::SIZE_W-1:0]     payload_size,
    input  logic                           cfg_we,
    input  logic [pmq_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [pmq_pkg::CFG_W-1:0]      cfg_data,
    output logic                           done,
    output logic [pmq_pkg::STAT_W-1:0]     status,
    output logic [pmq_pkg::TAG_W-1:0]      out_tag,
    output logic [pmq_pkg::PRI_W-1:0]      out_priority,
    output logic [pmq_pkg::SIZE_W-1:0]     out_size,
    output logic                           feed_event,
    output logic [pmq_pkg::TOTC_W-1:0]     total_count,
    output logic [pmq_pkg::BYTES_W-1:0]    total_bytes
);
    import pmq_pkg::*;

    pmq_cmd_t cmd;

    pmq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    pmq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .priority_req (priority_req),
        .is_request   (is_request),
        .message_tag  (message_tag),
        .payload_size (payload_size),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .out_size     (out_size),
        .feed_event   (feed_event),
        .total_count  (total_count),
        .total_bytes  (total_bytes)
    );

    `PMQ_ASSERT_NEXT(a_accept_then_busy, clk, rst_n, start && !busy, busy && !done)
    `PMQ_ASSERT_NEXT(a_busy_then_done, clk, rst_n, busy, done && !busy)
    `PMQ_ASSERT_IMPL(a_done_not_busy, clk, rst_n, done, !busy)
    `PMQ_ASSERT_IMPL(a_no_entry_zero, clk, rst_n, done && (status != ST_OK), (out_tag == '0) && (out_size == '0) && !feed_event)

endmodule
